/* src/speed_adaptive_moving_average_defines.svh */
// ----------------------------------------------------------------------------
// speed adaptive moving average - assertion macros
// concurrent assertion forms used by the top rtl file
// ----------------------------------------------------------------------------
`ifndef SPEED_ADAPTIVE_MOVING_AVERAGE_DEFINES_SVH
`define SPEED_ADAPTIVE_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SAMA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sama assertion failed");

// next-cycle implication, checked out of reset
`define SAMA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sama assertion failed");

`endif

/* src/sama_pkg.sv */
// ----------------------------------------------------------------------------
// sama_pkg
// types, sizes and helpers for the speed adaptive moving average
// ----------------------------------------------------------------------------
`default_nettype none

package sama_pkg;

    // history geometry
    localparam int MAX_WINDOW  = 20;
    localparam int SAMPLE_BITS = 16;
    localparam int SPEED_BITS  = 16;

    // derived widths
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int MAG_W  = SUM_W - 1;
    localparam int ITER_W = $clog2(MAG_W + 1);

    // speed thresholds, q8.8 m/s
    localparam logic [SPEED_BITS-1:0] SPEED_ONE   = SPEED_BITS'(256);
    localparam logic [SPEED_BITS-1:0] SPEED_TWO   = SPEED_BITS'(512);
    localparam logic [SPEED_BITS-1:0] SPEED_THREE = SPEED_BITS'(768);

    // window lengths per speed band
    localparam int WIN_CRAWL  = 5;
    localparam int WIN_SLOW   = 10;
    localparam int WIN_MEDIUM = 15;
    localparam int WIN_FAST   = 20;

    // request payload
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] angle_sample;
        logic        [SPEED_BITS-1:0]  vehicle_speed;
    } t_sama_in;

    // result payload
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_angle;
        logic        [CNT_W-1:0]       samples_used;
    } t_sama_out;

    // divider request
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    // divider status
    typedef struct packed {
        logic                          busy;
        logic signed [SAMPLE_BITS-1:0] quotient;
    } t_div_stat;

    // window length from speed, capped at history depth
    function automatic logic [CNT_W-1:0] pick_window(input logic [SPEED_BITS-1:0] speed);
        int w;
        if (speed < SPEED_ONE) begin
            w = WIN_CRAWL;
        end else if (speed <= SPEED_TWO) begin
            w = WIN_SLOW;
        end else if (speed <= SPEED_THREE) begin
            w = WIN_MEDIUM;
        end else begin
            w = WIN_FAST;
        end
        if (w > MAX_WINDOW) begin
            w = MAX_WINDOW;
        end
        return CNT_W'(w);
    endfunction

    // circular add of two values below the depth
    function automatic logic [PTR_W-1:0] wrap_add(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (CNT_W + 1)'(MAX_WINDOW)) begin
            s = s - (CNT_W + 1)'(MAX_WINDOW);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/sama_hist.sv */
// ----------------------------------------------------------------------------
// sama_hist
// sample history memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sama_hist
    import sama_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [PTR_W-1:0]              i_waddr,
    input  wire logic signed [SAMPLE_BITS-1:0] i_wdata,
    input  wire logic [PTR_W-1:0]              i_raddr,
    output logic signed [SAMPLE_BITS-1:0]      o_rdata
);

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/sama_div.sv */
// ----------------------------------------------------------------------------
// sama_div
// serial restoring divider, signed sum over unsigned count, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sama_div
    import sama_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_div_req  i_req,
    output t_div_stat      o_stat
);

    logic              r_busy;
    logic [ITER_W-1:0] r_iter;
    logic [CNT_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_den;
    logic              r_neg;

    logic [SUM_W-1:0]  abs_dvd;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;
    logic [MAG_W-1:0]  signed_quo;

    // magnitude of the dividend and one trial subtraction
    always_comb begin
        abs_dvd    = i_req.dividend[SUM_W-1] ? SUM_W'(-i_req.dividend)
                                             : SUM_W'(i_req.dividend);
        trial      = {r_rem, r_quo[MAG_W-1]};
        diff       = trial - {1'b0, r_den};
        ge         = (trial >= {1'b0, r_den});
        signed_quo = r_neg ? MAG_W'(-r_quo) : r_quo;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_iter <= ITER_W'(MAG_W);
        end else if (r_busy) begin
            r_iter <= r_iter - 1'b1;
            r_busy <= (r_iter != ITER_W'(1));
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[SUM_W-1];
            r_quo <= abs_dvd[MAG_W-1:0];
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[MAG_W-2:0], ge};
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.quotient = signed_quo[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

/* src/speed_adaptive_moving_average.sv */
// ----------------------------------------------------------------------------
// speed_adaptive_moving_average
// mean of the newest angle samples over a window chosen by vehicle speed
// ----------------------------------------------------------------------------
//  channel   valid    ready    payload
//  request   i_valid  o_ready  i_data (t_sama_in)
//  result    o_valid  i_ready  o_data (t_sama_out)
//
//  one request passes through an accept step, one history read per held
//  sample through the single memory read port, the registered read, a
//  divider start, twenty quotient bits and an output load.
//  o_ready is high only while the sequencer is idle.
//  a finished result waits in the output register; a stalled result holds
//  the divider result until the register frees.
//  reset is synchronous, active low, and empties the history.
// ----------------------------------------------------------------------------
`default_nettype none

`include "speed_adaptive_moving_average_defines.svh"

module speed_adaptive_moving_average
    import sama_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_sama_in  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_sama_out      o_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]                    r_state;
    logic [CNT_W-1:0]              r_held;
    logic [PTR_W-1:0]              r_oldest;
    logic [CNT_W-1:0]              r_idx;
    logic [PTR_W-1:0]              r_rptr;
    logic                          r_rd_vld;
    logic signed [SUM_W-1:0]       r_sum;
    logic                          r_out_valid;
    t_sama_out                     r_out;

    logic                          accept;
    logic [CNT_W-1:0]              win;
    logic [CNT_W-1:0]              keep;
    logic [CNT_W-1:0]              drop;
    logic [PTR_W-1:0]              n_oldest;
    logic [PTR_W-1:0]              slot;
    logic                          issue;
    logic                          read_done;
    logic                          load_out;
    logic signed [SAMPLE_BITS-1:0] rdata;
    t_div_req                      div_req;
    t_div_stat                     div_stat;

    // drop oldest samples until the new one fits the window
    always_comb begin
        accept   = i_valid && o_ready;
        win      = pick_window(i_data.vehicle_speed);
        keep     = (r_held >= win) ? win - 1'b1 : r_held;
        drop     = r_held - keep;
        n_oldest = wrap_add(CNT_W'(r_oldest), drop);
        slot     = wrap_add(CNT_W'(n_oldest), keep);
    end

    // read and finish conditions
    always_comb begin
        issue     = (r_state == ST_READ) && (r_idx != r_held);
        read_done = (r_state == ST_READ) && (r_idx == r_held) && !r_rd_vld;
        load_out  = (r_state == ST_DIV) && !div_stat.busy && (!r_out_valid || i_ready);
    end

    // history store
    sama_hist u_hist (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (slot),
        .i_wdata (i_data.angle_sample),
        .i_raddr (r_rptr),
        .o_rdata (rdata)
    );

    // divider request
    always_comb begin
        div_req.start    = read_done;
        div_req.dividend = r_sum;
        div_req.divisor  = r_held;
    end

    sama_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    // sequencer and history bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_held   <= '0;
            r_oldest <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_held   <= keep + 1'b1;
                        r_oldest <= n_oldest;
                        r_state  <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (read_done) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // read walk and accumulation
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx  <= '0;
            r_rptr <= n_oldest;
            r_sum  <= '0;
        end else begin
            if (issue) begin
                r_idx  <= r_idx + 1'b1;
                r_rptr <= wrap_add(CNT_W'(r_rptr), CNT_W'(1));
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + SUM_W'(rdata);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.filtered_angle <= div_stat.quotient;
            r_out.samples_used   <= r_held;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // checks
    `SAMA_ASSERT_NOW(a_held_max, i_clk, i_rst_n, 1'b1, r_held <= CNT_W'(MAX_WINDOW))
    `SAMA_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, accept, r_state == ST_READ)
    `SAMA_ASSERT_NOW(a_busy_holds, i_clk, i_rst_n, r_state != ST_IDLE, r_held != '0)
    `SAMA_ASSERT_NEXT(a_div_starts, i_clk, i_rst_n, read_done, div_stat.busy)

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - speed adaptive moving average testbench
// drives angle/speed requests with random gaps and result stalls, predicts the
// windowed mean and held count per request and compares every result in order
// ----------------------------------------------------------------------------

module tb;
    import sama_pkg::t_sama_in;
    import sama_pkg::t_sama_out;
    import sama_pkg::MAX_WINDOW;
    import sama_pkg::SAMPLE_BITS;
    import sama_pkg::SPEED_BITS;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 7;
    localparam int MAX_GAP         = 17;
    localparam int RANDOM_REQUESTS = 1525;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int REPORT_LIMIT    = 10;

    // speed band edges in q8.8 m/s
    localparam logic [SPEED_BITS-1:0] ONE_MPS   = 16'd256;
    localparam logic [SPEED_BITS-1:0] TWO_MPS   = 16'd512;
    localparam logic [SPEED_BITS-1:0] THREE_MPS = 16'd768;

    // window lengths per band
    localparam int LEN_CRAWL = 5;
    localparam int LEN_SLOW  = 10;
    localparam int LEN_MID   = 15;
    localparam int LEN_FAST  = 20;

    localparam logic signed [SAMPLE_BITS-1:0] ANGLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] ANGLE_MIN = 16'sh8000;

    typedef enum int {BAND_CRAWL, BAND_SLOW, BAND_MID, BAND_FAST} t_speed_band;

    // tracks the angle history and the queue of pending means
    class t_window_mean_scoreboard;
        logic signed [SAMPLE_BITS-1:0] angle_history[MAX_WINDOW];
        int        held;
        int        oldest;
        t_sama_out expected_means[$];
        int        failures;

        function new();
            held     = 0;
            oldest   = 0;
            failures = 0;
        endfunction

        function int pending();
            return expected_means.size();
        endfunction

        // update the history for one accepted request and queue its mean
        function void note_request(t_sama_in req);
            int        window;
            longint    total;
            longint    mean;
            t_sama_out res;
            if (req.vehicle_speed < ONE_MPS) begin
                window = LEN_CRAWL;
            end else if (req.vehicle_speed <= TWO_MPS) begin
                window = LEN_SLOW;
            end else if (req.vehicle_speed <= THREE_MPS) begin
                window = LEN_MID;
            end else begin
                window = LEN_FAST;
            end
            if (window > MAX_WINDOW) begin
                window = MAX_WINDOW;
            end
            // drop oldest samples until the new one fits the window
            while (held >= window) begin
                oldest = (oldest + 1) % MAX_WINDOW;
                held--;
            end
            angle_history[(oldest + held) % MAX_WINDOW] = req.angle_sample;
            held++;
            total = 0;
            for (int k = 0; k < held; k++) begin
                total += angle_history[(oldest + k) % MAX_WINDOW];
            end
            // integer division truncates toward zero
            mean = total / held;
            res.filtered_angle = mean[SAMPLE_BITS-1:0];
            res.samples_used   = held[4:0];
            expected_means = {expected_means, res};
        endfunction

        // compare one accepted result with the oldest expected mean
        function void check_result(t_sama_out got);
            t_sama_out want;
            if (expected_means.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("unexpected result: angle %0d used %0d",
                             got.filtered_angle, got.samples_used);
                end
                return;
            end
            want = expected_means.pop_front();
            if (got.filtered_angle !== want.filtered_angle ||
                got.samples_used !== want.samples_used) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("mismatch: expected angle %0d used %0d, got angle %0d used %0d",
                             want.filtered_angle, want.samples_used,
                             got.filtered_angle, got.samples_used);
                end
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_sama_in  i_data;
    logic      o_valid;
    logic      i_ready;
    t_sama_out o_data;

    t_window_mean_scoreboard scoreboard = new();
    bit steady_flow = 1'b0;
    int idle_cycles = 0;

    speed_adaptive_moving_average dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // present one request after a random gap and wait for its handshake
    task automatic send_request(input logic signed [SAMPLE_BITS-1:0] angle,
                                input logic [SPEED_BITS-1:0] speed);
        t_sama_in req;
        int       gap;
        req.angle_sample  = angle;
        req.vehicle_speed = speed;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_data  <= req;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        scoreboard.note_request(req);
    endtask

    // hold off new requests until every pending result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
    endtask

    // request side
    initial begin
        t_speed_band                   band;
        int                            band_left;
        int                            pick;
        logic signed [SAMPLE_BITS-1:0] angle;
        logic [SPEED_BITS-1:0]         speed;
        band_left = 0;
        band      = BAND_CRAWL;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // band edges and sample extremes while the history grows
        send_request(ANGLE_MAX, 16'd0);
        send_request(ANGLE_MAX, ONE_MPS - 16'd1);
        send_request(ANGLE_MIN, ONE_MPS);
        send_request(ANGLE_MIN, TWO_MPS);
        send_request(-16'sd1, TWO_MPS + 16'd1);
        send_request(16'sd1, THREE_MPS);
        send_request(16'sd0, THREE_MPS + 16'd1);
        // fill the full window with alternating extremes
        for (int k = 0; k < 13; k++) begin
            send_request((k % 2) ? ANGLE_MIN : ANGLE_MAX, 16'hffff);
        end
        send_request(ANGLE_MIN, 16'hffff);
        // window shrink from twenty down to five, then growth under wider windows
        send_request(16'sd12345, 16'd0);
        send_request(-16'sd12345, 16'd600);
        send_request(-16'sd7, 16'd300);
        drain_results();

        // random requests, speed mostly held in one band for a stretch at a time
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 64 == 0) begin
                steady_flow = ($urandom_range(0, 3) == 0);
            end
            if (n % 400 == 399) begin
                drain_results();
            end
            if (band_left == 0) begin
                band      = t_speed_band'($urandom_range(0, 3));
                band_left = $urandom_range(5, 40);
            end
            band_left--;

            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case (band)
                    BAND_CRAWL: speed = SPEED_BITS'($urandom_range(0, 255));
                    BAND_SLOW:  speed = SPEED_BITS'($urandom_range(256, 512));
                    BAND_MID:   speed = SPEED_BITS'($urandom_range(513, 768));
                    default:    speed = SPEED_BITS'($urandom_range(769, 65535));
                endcase
            end else if (pick < 85) begin
                case ($urandom_range(0, 5))
                    0:       speed = ONE_MPS - 16'd1;
                    1:       speed = ONE_MPS;
                    2:       speed = TWO_MPS;
                    3:       speed = TWO_MPS + 16'd1;
                    4:       speed = THREE_MPS;
                    default: speed = THREE_MPS + 16'd1;
                endcase
            end else begin
                speed = SPEED_BITS'($urandom_range(0, 65535));
            end

            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                angle = SAMPLE_BITS'($urandom_range(0, 65535));
            end else if (pick < 75) begin
                angle = ANGLE_MAX;
            end else if (pick < 90) begin
                angle = ANGLE_MIN;
            end else begin
                angle = SAMPLE_BITS'(int'($urandom_range(0, 15)) - 8);
            end
            send_request(angle, speed);
        end

        // wind down and report
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        scoreboard.failures += scoreboard.pending();
        if (scoreboard.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side with random stalls
    initial begin
        int stall;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            scoreboard.check_result(o_data);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
